// ----- rtl/core/nmea_sentence_deframer_macros.svh -----
// Assertion macros for the NMEA sentence deframer.
// Expects clk and rst_n in the scope of each use.
`ifndef NMEA_SENTENCE_DEFRAMER_MACROS_SVH
`define NMEA_SENTENCE_DEFRAMER_MACROS_SVH

// same-cycle implication
`define NSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/nsd_pkg.sv -----
// Package for the NMEA sentence deframer: phase type, character and status codes,
// tag and hex-digit helpers. No dependencies.
package nsd_pkg;

  localparam int MAX_FIELDS_DEF = 24;
  localparam int FIELD_LEN_DEF  = 16;
  localparam logic [7:0] MIN_LEN_RST = 8'd16;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam int         TAG_LEN   = 6;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_TAG   = 3'd2;
  localparam logic [2:0] ST_CSUM_ERR  = 3'd3;
  localparam logic [2:0] ST_NO_FIELDS = 3'd4;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_HEAD   = 3'd1,
    PH_FIELDS = 3'd2,
    PH_HEX1   = 3'd3,
    PH_HEX2   = 3'd4,
    PH_TAIL   = 3'd5
  } phase_t;

  // "$GNGGA"
  function automatic logic [7:0] tag_gga(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h4e;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h47;
      3'd5:    ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "$GNRMC"
  function automatic logic [7:0] tag_rmc(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h4e;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4d;
      3'd5:    ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // hex digit value; anything else reads as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39)      v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    return v[3:0];
  endfunction

endpackage

// ----- rtl/core/nmea_sentence_deframer.sv -----
// NMEA 0183 sentence deframer, top level: tag check, checksum, field split.
// Depends on nsd_pkg and nmea_sentence_deframer_macros.svh.
//
//  channel  dir  handshake            beat
//  in_      in   in_valid / in_stall  one sentence character, last flag
//  out_     out  out_valid/out_stall  field character or end-of-sentence status
//  cfg_     in   cfg_valid/cfg_ready  min_length (always ready)
//
// One character per cycle unless stalled; its result shows in the next cycle.
// Per-sentence state, min_length and the output register are the sequential parts.
// in_stall rises only while a result sits in the output register and out_stall is high.
// Synchronous active-low reset: min_length back to 16, sentence state cleared.
`include "nmea_sentence_deframer_macros.svh"

module nmea_sentence_deframer #(
  parameter int MAX_FIELDS = nsd_pkg::MAX_FIELDS_DEF,
  parameter int FIELD_LEN  = nsd_pkg::FIELD_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [4:0] out_field_index,
  output logic [3:0] out_field_pos,
  output logic [7:0] out_field_char,
  output logic       out_sentence_type,
  output logic [2:0] out_status,
  output logic [4:0] out_field_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int FLD_W   = $clog2(MAX_FIELDS + 1);
  localparam int POS_W   = $clog2(FIELD_LEN);
  localparam int CNT_W   = FLD_W + 1;
  localparam int CNT_CAP = (MAX_FIELDS < 31) ? MAX_FIELDS : 31;

  // config
  logic [7:0] min_length_r;

  // sentence state
  nsd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       char_count_r, char_count_nxt;
  logic [1:0]       tag_match_r, tag_match_nxt;   // bit0 GGA, bit1 RMC
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       rx_sum_r, rx_sum_nxt;
  logic [FLD_W-1:0] field_r, field_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             seen_star_r, seen_star_nxt;
  logic             seen_comma_r, seen_comma_nxt;
  logic             bad_start_r, bad_start_nxt;

  // output register
  logic       out_valid_r;
  logic       kind_r, type_r;
  logic [4:0] index_r, count_r;
  logic [3:0] fpos_r;
  logic [7:0] fchar_r;
  logic [2:0] status_r;

  logic             in_fire;
  logic             emit;
  logic [2:0]       status_nxt;
  logic [CNT_W-1:0] cnt_raw, cnt_sat;
  logic [7:0]       c;

  assign c         = in_char_code;
  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      nsd_pkg::PH_START: phase_nxt = nsd_pkg::PH_HEAD;
      nsd_pkg::PH_HEAD: begin
        if (c == nsd_pkg::CH_STAR)       phase_nxt = nsd_pkg::PH_HEX1;
        else if (c == nsd_pkg::CH_COMMA) phase_nxt = nsd_pkg::PH_FIELDS;
      end
      nsd_pkg::PH_FIELDS: begin
        if (c == nsd_pkg::CH_STAR) phase_nxt = nsd_pkg::PH_HEX1;
      end
      nsd_pkg::PH_HEX1: phase_nxt = nsd_pkg::PH_HEX2;
      nsd_pkg::PH_HEX2: phase_nxt = nsd_pkg::PH_TAIL;
      nsd_pkg::PH_TAIL: phase_nxt = nsd_pkg::PH_TAIL;
      default:          phase_nxt = nsd_pkg::PH_START;
    endcase
    if (in_last) phase_nxt = nsd_pkg::PH_START;
  end

  // datapath and result
  always_comb begin
    char_count_nxt = (char_count_r != 8'hff) ? char_count_r + 8'd1 : char_count_r;
    tag_match_nxt  = tag_match_r;
    xor_nxt        = xor_r;
    rx_sum_nxt     = rx_sum_r;
    field_nxt      = field_r;
    pos_nxt        = pos_r;
    seen_star_nxt  = seen_star_r;
    seen_comma_nxt = seen_comma_r;
    bad_start_nxt  = bad_start_r;
    emit           = 1'b0;

    if (char_count_r < 8'(nsd_pkg::TAG_LEN)) begin
      if (c != nsd_pkg::tag_gga(char_count_r[2:0])) tag_match_nxt[0] = 1'b0;
      if (c != nsd_pkg::tag_rmc(char_count_r[2:0])) tag_match_nxt[1] = 1'b0;
    end

    unique case (phase_r)
      nsd_pkg::PH_START: bad_start_nxt = (c != nsd_pkg::CH_DOLLAR);
      nsd_pkg::PH_HEAD, nsd_pkg::PH_FIELDS: begin
        if (c == nsd_pkg::CH_STAR) begin
          seen_star_nxt = 1'b1;
        end else begin
          xor_nxt = xor_r ^ c;
          if (c == nsd_pkg::CH_COMMA) begin
            if (phase_r == nsd_pkg::PH_HEAD) begin
              seen_comma_nxt = 1'b1;
              field_nxt      = '0;
            end else if (field_r < FLD_W'(MAX_FIELDS)) begin
              field_nxt = field_r + 1'b1;
            end
            pos_nxt = '0;
          end else if (phase_r == nsd_pkg::PH_FIELDS) begin
            // drop overlong fields and fields past the limit
            if (field_r < FLD_W'(MAX_FIELDS) && pos_r < POS_W'(FIELD_LEN - 1)) begin
              emit    = 1'b1;
              pos_nxt = pos_r + 1'b1;
            end
          end
        end
      end
      nsd_pkg::PH_HEX1: rx_sum_nxt = {nsd_pkg::nibble_of(c), 4'h0};
      nsd_pkg::PH_HEX2: rx_sum_nxt = {rx_sum_r[7:4], nsd_pkg::nibble_of(c)};
      nsd_pkg::PH_TAIL: ;
      default: ;
    endcase

    cnt_raw = {1'b0, field_nxt} + CNT_W'(1);
    cnt_sat = (cnt_raw > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : cnt_raw;
    if (!seen_comma_nxt) cnt_sat = '0;

    priority if (char_count_nxt < min_length_r)
      status_nxt = nsd_pkg::ST_SHORT;
    else if (bad_start_nxt || tag_match_nxt == 2'b00 ||
             char_count_nxt < 8'(nsd_pkg::TAG_LEN))
      status_nxt = nsd_pkg::ST_BAD_TAG;
    else if (!seen_star_nxt || xor_nxt != rx_sum_nxt)
      status_nxt = nsd_pkg::ST_CSUM_ERR;
    else if (!seen_comma_nxt)
      status_nxt = nsd_pkg::ST_NO_FIELDS;
    else
      status_nxt = nsd_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= nsd_pkg::MIN_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_length_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_last)) begin
      phase_r      <= nsd_pkg::PH_START;
      char_count_r <= '0;
      tag_match_r  <= 2'b11;
      xor_r        <= '0;
      rx_sum_r     <= '0;
      field_r      <= '0;
      pos_r        <= '0;
      seen_star_r  <= 1'b0;
      seen_comma_r <= 1'b0;
      bad_start_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      char_count_r <= char_count_nxt;
      tag_match_r  <= tag_match_nxt;
      xor_r        <= xor_nxt;
      rx_sum_r     <= rx_sum_nxt;
      field_r      <= field_nxt;
      pos_r        <= pos_nxt;
      seen_star_r  <= seen_star_nxt;
      seen_comma_r <= seen_comma_nxt;
      bad_start_r  <= bad_start_nxt;
    end
  end

  // output register; reloads whenever it is empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && (in_last || emit)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_last || emit)) begin
      type_r <= tag_match_nxt[1];
      if (in_last) begin
        kind_r   <= nsd_pkg::KIND_STATUS;
        index_r  <= '0;
        fpos_r   <= '0;
        fchar_r  <= '0;
        status_r <= status_nxt;
        count_r  <= 5'(cnt_sat);
      end else begin
        kind_r   <= nsd_pkg::KIND_CHAR;
        index_r  <= 5'(field_r);
        fpos_r   <= 4'(pos_r);
        fchar_r  <= c;
        status_r <= nsd_pkg::ST_OK;
        count_r  <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_field_index   = index_r;
  assign out_field_pos     = fpos_r;
  assign out_field_char    = fchar_r;
  assign out_sentence_type = type_r;
  assign out_status        = status_r;
  assign out_field_count   = count_r;

  `NSD_ASSERT_NEXT(a_last_clears, in_fire && in_last,
                   phase_r == nsd_pkg::PH_START && char_count_r == 8'd0,
                   "sentence state not cleared after last beat")
  `NSD_ASSERT_NEXT(a_result_loaded, in_fire && (in_last || emit),
                   out_valid_r && (kind_r == $past(in_last)),
                   "result beat not loaded")
  `NSD_ASSERT_NOW(a_char_in_range, out_valid_r && kind_r == nsd_pkg::KIND_CHAR,
                  int'(index_r) < MAX_FIELDS && status_r == nsd_pkg::ST_OK,
                  "character beat out of field range")
  `NSD_ASSERT_NOW(a_nofields_count,
                  out_valid_r && kind_r == nsd_pkg::KIND_STATUS &&
                  status_r == nsd_pkg::ST_NO_FIELDS,
                  count_r == 5'd0, "no-fields status with nonzero count")

endmodule

// ----- tb/sv/nmea_sentence_deframer_tb.sv -----
// Self-checking testbench for nmea_sentence_deframer: directed cases, then
// random sentences under random idling. Depends on nsd_pkg and the block's RTL only.
`timescale 1ns / 1ps

module nmea_sentence_deframer_tb;
  import nsd_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          PHASE_BEATS = 40;    // random beats per config setting
  localparam logic [47:0] GGA_TAG     = "$GNGGA";
  localparam logic [47:0] RMC_TAG     = "$GNRMC";

  // one result beat, field for field as on the out_ ports
  typedef struct packed {
    logic       kind;
    logic [4:0] field_index;
    logic [3:0] field_pos;
    logic [7:0] field_char;
    logic       sentence_type;
    logic [2:0] status;
    logic [4:0] field_count;
  } deframe_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [4:0] out_field_index;
  logic [3:0] out_field_pos;
  logic [7:0] out_field_char;
  logic       out_sentence_type;
  logic [2:0] out_status;
  logic [4:0] out_field_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  nmea_sentence_deframer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_field_index   (out_field_index),
    .out_field_pos     (out_field_pos),
    .out_field_char    (out_field_char),
    .out_sentence_type (out_sentence_type),
    .out_status        (out_status),
    .out_field_count   (out_field_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sentence predictor: its own copy of min_length and of the per-sentence state.
  // ---------------------------------------------------------------------------
  deframe_beat_t deframe_q[$];    // predicted beats, oldest first
  logic [7:0]    line_q[$];       // sentence being built for the sender

  logic [7:0] p_min_len = MIN_LEN_RST;
  phase_t     p_phase;
  logic [7:0] p_count;            // saturates at 255
  logic [1:0] p_match;            // bit 0 GGA still matching, bit 1 RMC
  logic [7:0] p_xor;
  logic [7:0] p_rx_sum;
  logic [4:0] p_field;
  logic [3:0] p_pos;
  logic       p_star;
  logic       p_comma;
  logic       p_bad_start;

  int errors      = 0;
  int beats_sent  = 0;
  int cycle_count = 0;
  int gap_pct     = 0;            // sender idle chance at each burst boundary
  int hold_cycles = 0;            // receiver hold-off request, counted down by rx side

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - 8'h30);
    if (c >= "A" && c <= "F") return 4'(c - 8'h37);
    if (c >= "a" && c <= "f") return 4'(c - 8'h57);
    return 4'h0;
  endfunction

  task automatic clear_sentence;
    p_phase     = PH_START;
    p_count     = 8'd0;
    p_match     = 2'b11;
    p_xor       = 8'h00;
    p_rx_sum    = 8'h00;
    p_field     = 5'd0;
    p_pos       = 4'd0;
    p_star      = 1'b0;
    p_comma     = 1'b0;
    p_bad_start = 1'b0;
  endtask

  // advance the sentence state by one accepted character, queue what it yields
  task automatic predict_char(input logic [7:0] c, input logic fin);
    deframe_beat_t b;
    logic          emit;
    logic [4:0]    e_field;
    logic [3:0]    e_pos;
    int            idx;
    int            cnt;
    logic [2:0]    st;
    emit    = 1'b0;
    e_field = 5'd0;
    e_pos   = 4'd0;
    idx     = int'(p_count);
    if (idx < TAG_LEN) begin
      if (c != GGA_TAG[8*(5-idx) +: 8]) p_match[0] = 1'b0;
      if (c != RMC_TAG[8*(5-idx) +: 8]) p_match[1] = 1'b0;
    end
    if (p_count != 8'd255) p_count = p_count + 8'd1;

    case (p_phase)
      PH_START: begin
        // leading character only sets bad_start, never enters the checksum
        p_bad_start = (c != CH_DOLLAR);
        p_phase     = PH_HEAD;
      end
      PH_HEAD, PH_FIELDS: begin
        if (c == CH_STAR) begin
          p_star  = 1'b1;
          p_phase = PH_HEX1;
        end else begin
          p_xor = p_xor ^ c;
          if (c == CH_COMMA) begin
            if (p_phase == PH_HEAD) begin
              p_comma = 1'b1;
              p_field = 5'd0;
              p_phase = PH_FIELDS;
            end else if (p_field < MAX_FIELDS_DEF) begin
              p_field = p_field + 5'd1;
            end
            p_pos = 4'd0;
          end else if (p_phase == PH_FIELDS && p_field < MAX_FIELDS_DEF &&
                       p_pos < FIELD_LEN_DEF - 1) begin
            emit    = 1'b1;
            e_field = p_field;
            e_pos   = p_pos;
            p_pos   = p_pos + 4'd1;
          end
        end
      end
      PH_HEX1: begin
        p_rx_sum = {hex_value(c), 4'h0};
        p_phase  = PH_HEX2;
      end
      PH_HEX2: begin
        p_rx_sum[3:0] = hex_value(c);
        p_phase       = PH_TAIL;
      end
      default: ;
    endcase

    b = '0;
    b.sentence_type = p_match[1];
    if (fin) begin
      cnt = p_comma ? int'(p_field) + 1 : 0;
      if (cnt > MAX_FIELDS_DEF) cnt = MAX_FIELDS_DEF;
      if (cnt > 31) cnt = 31;
      // priority: short, tag, checksum, no fields
      if (p_count < p_min_len) st = ST_SHORT;
      else if (p_bad_start || p_match == 2'b00 || p_count < TAG_LEN) st = ST_BAD_TAG;
      else if (!p_star || p_xor != p_rx_sum) st = ST_CSUM_ERR;
      else if (!p_comma) st = ST_NO_FIELDS;
      else st = ST_OK;
      b.kind        = KIND_STATUS;
      b.status      = st;
      b.field_count = 5'(cnt);
      deframe_q.push_back(b);
      clear_sentence();
    end else if (emit) begin
      b.kind        = KIND_CHAR;
      b.field_index = e_field;
      b.field_pos   = e_pos;
      b.field_char  = c;
      deframe_q.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted out_ beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    deframe_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (deframe_q.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing predicted, expected none, actual kind %0d",
                 $time, out_kind);
      end else begin
        want = deframe_q.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("field_index", want.field_index, out_field_index);
        check_field("field_pos", want.field_pos, out_field_pos);
        check_field("field_char", want.field_char, out_field_char);
        check_field("sentence_type", want.sentence_type, out_sentence_type);
        check_field("status", want.status, out_status);
        check_field("field_count", want.field_count, out_field_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nmea_sentence_deframer_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall modes per window, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : rx_pattern
    int mode;
    int window;
    int tick;
    mode   = 0;
    window = 0;
    tick   = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_cycles > 0) begin
        out_stall   <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        if (window == 0) begin
          mode   = $urandom_range(0, 3);
          window = $urandom_range(16, 96);
        end
        window--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and config helpers.
  // ---------------------------------------------------------------------------
  // offer one character; holds the payload until the beat is taken
  task automatic send_char(input logic [7:0] c, input logic fin);
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last      <= fin;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    predict_char(c, fin);
  endtask

  // send line_q in bursts; a gap may open at each burst boundary
  task automatic send_line;
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < line_q.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 99) < gap_pct) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      burst_left--;
      send_char(line_q[i], i == line_q.size() - 1);
    end
  endtask

  // block idle: all predictions out, then idle clocks for the result register
  task automatic drain;
    in_valid <= 1'b0;
    while (deframe_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_min_len(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_min_len = value;
  endtask

  // ---------------------------------------------------------------------------
  // Sentence builders.
  // ---------------------------------------------------------------------------
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  task automatic add_hex(input logic [7:0] value, input logic lower);
    line_q.push_back(hex_char(value[7:4], lower));
    line_q.push_back(hex_char(value[3:0], lower));
  endtask

  // checksum of everything after the leading character
  function automatic logic [7:0] line_xor();
    logic [7:0] x;
    x = 8'h00;
    for (int i = 1; i < line_q.size(); i++) x = x ^ line_q[i];
    return x;
  endfunction

  function automatic logic [7:0] field_byte();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h2e, 8'h5a));
    c = 8'($urandom_range(0, 255));
    if (c == CH_STAR && $urandom_range(0, 3) != 0) c = 8'h2d;
    return c;
  endfunction

  // mostly well-formed sentences with random content, some noise and broken ones
  task automatic build_sentence;
    int         kind;
    int         k;
    int         nf;
    int         flen;
    int         cut;
    logic       lower;
    logic [7:0] csum;
    line_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      k = $urandom_range(1, 12);
      repeat (k) line_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) line_q[0] = CH_DOLLAR;
    end else begin
      line_q.push_back(CH_DOLLAR);
      if ($urandom_range(0, 1) == 0) add_text("GNGGA");
      else add_text("GNRMC");
      if ($urandom_range(0, 9) == 0) line_q[$urandom_range(1, 5)] = 8'($urandom_range(0, 255));
      k  = $urandom_range(0, 99);
      nf = (k < 8) ? 0 : (k < 93) ? $urandom_range(1, 6) : $urandom_range(20, 28);
      repeat (nf) begin
        line_q.push_back(CH_COMMA);
        if (nf > 6) flen = $urandom_range(0, 2);
        else if ($urandom_range(0, 4) == 0) flen = $urandom_range(12, 18);
        else flen = $urandom_range(0, 5);
        repeat (flen) line_q.push_back(field_byte());
      end
      csum  = line_xor();
      lower = $urandom_range(0, 1);
      k     = $urandom_range(0, 99);
      if (k >= 4) begin
        line_q.push_back(CH_STAR);
        if (k < 80) add_hex(csum, lower);
        else if (k < 88) add_hex(csum ^ (8'h01 << $urandom_range(0, 7)), lower);
        else if (k < 94) line_q.push_back(hex_char(csum[7:4], lower));
        else add_text("Gz");
      end
      k = $urandom_range(0, 9);
      if (k < 3) add_text("\r\n");
      else if (k == 3) add_text(",9,");
      if ($urandom_range(0, 19) == 0) line_q[0] = 8'($urandom_range(0, 255));
      if (kind < 22) begin
        cut = $urandom_range(1, line_q.size());
        while (line_q.size() > cut) void'(line_q.pop_back());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // min_length out of reset is 16: an 11-character valid sentence is too short
  task automatic test_reset_min_length;
    line_q.delete();
    add_text("$GNRMC,A");
    line_q.push_back(CH_STAR);
    add_hex(line_xor() ^ CH_STAR, 1'b0);
    send_line();
    drain();
  endtask

  task automatic test_framing_cases;
    logic [7:0] csum;
    write_min_len(8'd0);
    // good GGA with the character extremes inside a field, then an empty field
    line_q.delete();
    add_text("$GNGGA,");
    line_q.push_back(8'hff);
    line_q.push_back(8'h00);
    line_q.push_back(CH_COMMA);
    csum = line_xor();
    line_q.push_back(CH_STAR);
    add_hex(csum, 1'b1);
    send_line();
    // lone character that is not the leading dollar
    line_q.delete();
    line_q.push_back(8'h23);
    send_line();
    // tag cut short
    line_q.delete();
    add_text("$GN");
    send_line();
    // star never arrives
    line_q.delete();
    add_text("$GNGGA,1");
    send_line();
    // no comma before the star, checksum digits not hex
    line_q.delete();
    add_text("$GNRMC*zq");
    send_line();
    drain();
  endtask

  // min_length 255 with a 264-character sentence: count saturates, still passes
  task automatic test_long_sentence;
    logic [7:0] csum;
    write_min_len(8'd255);
    line_q.delete();
    add_text("$GNGGA");
    repeat (17) begin
      line_q.push_back(CH_COMMA);
      repeat (14) line_q.push_back(field_byte() | 8'h40);
    end
    csum = line_xor();
    line_q.push_back(CH_STAR);
    add_hex(csum, 1'b0);
    send_line();
    line_q.delete();
    add_text("$GNRMC,1");
    csum = line_xor();
    line_q.push_back(CH_STAR);
    add_hex(csum, 1'b0);
    send_line();
    drain();
  endtask

  // receiver holds off long enough for the block to back up into in_stall
  task automatic test_output_hold_off;
    write_min_len(8'd12);
    gap_pct     = 0;
    hold_cycles = 200;
    repeat (3) begin
      build_sentence();
      send_line();
    end
    drain();
  endtask

  task automatic test_random_traffic;
    int         start;
    logic [7:0] min_len;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       begin min_len = 8'd0;  gap_pct = 0;  end   // no idling at all
        1:       begin min_len = 8'd12; gap_pct = 30; end
        2:       begin min_len = 8'($urandom_range(0, 255)); gap_pct = 10; end
        3:       begin min_len = 8'd24; gap_pct = 60; end
        default: begin min_len = 8'($urandom_range(1, 40)); gap_pct = 20; end
      endcase
      write_min_len(min_len);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        build_sentence();
        send_line();
      end
      drain();
    end
  endtask

  initial begin
    clear_sentence();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_min_length();
    test_framing_cases();
    test_long_sentence();
    test_output_hold_off();
    test_random_traffic();

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("nmea_sentence_deframer_tb OK");
    end else begin
      $display("nmea_sentence_deframer_tb NOT OK");
    end
    $finish;
  end

endmodule
